FILE: hdl/ssu_pkg.sv
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared types and constants for the sensor sample unpacker.
// ----------------------------------------------------------------------------
package ssu_pkg;

	localparam int unsigned ByteBits   = 8;
	localparam int unsigned MaxStorage = 8;
	localparam int unsigned WordBits   = 64;
	localparam int unsigned CfgIdxW    = 3;
	localparam int unsigned CfgDataW   = 16;

	// register indexes on the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_MSB_FIRST     = 3'd0,
		REG_SIGNED_MODE   = 3'd1,
		REG_SIG_BITS      = 3'd2,
		REG_STORAGE_BYTES = 3'd3,
		REG_REPEAT_COUNT  = 3'd4,
		REG_SHIFT_AMOUNT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic        msb_first;
		logic        signed_mode;
		logic [6:0]  sig_bits;
		logic [4:0]  storage_bytes;
		logic [15:0] repeat_count;
		logic [5:0]  shift_amount;
	} cfg_t;

	typedef struct packed {
		logic [63:0] raw_bytes;
		logic [15:0] element_index;
		logic [19:0] buffer_bytes;
	} req_t;

	typedef struct packed {
		logic [63:0] sample_bits;
		logic        sample_signed;
		logic        decode_error;
	} res_t;

endpackage

FILE: hdl/ssu_cfg_regs.sv
// ----------------------------------------------------------------------------
// ssu_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module ssu_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ssu_pkg::CfgIdxW-1:0]         cfg_idx,
	input  logic [ssu_pkg::CfgDataW-1:0]        cfg_data,
	output ssu_pkg::cfg_t                       cfg
);

	ssu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.msb_first     <= 1'b0;
			cfg_q.signed_mode   <= 1'b0;
			cfg_q.sig_bits      <= 7'd16;
			cfg_q.storage_bytes <= 5'd2;
			cfg_q.repeat_count  <= 16'd1;
			cfg_q.shift_amount  <= 6'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ssu_pkg::REG_MSB_FIRST:     cfg_q.msb_first     <= cfg_data[0];
				ssu_pkg::REG_SIGNED_MODE:   cfg_q.signed_mode   <= cfg_data[0];
				ssu_pkg::REG_SIG_BITS:      cfg_q.sig_bits      <= cfg_data[6:0];
				ssu_pkg::REG_STORAGE_BYTES: cfg_q.storage_bytes <= cfg_data[4:0];
				ssu_pkg::REG_REPEAT_COUNT:  cfg_q.repeat_count  <= cfg_data[15:0];
				ssu_pkg::REG_SHIFT_AMOUNT:  cfg_q.shift_amount  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/ssu_decode.sv
// ----------------------------------------------------------------------------
// ssu_decode
// Combinational decode of one element: byte order, shift, mask, sign.
// ----------------------------------------------------------------------------
module ssu_decode (
	input  ssu_pkg::cfg_t cfg,
	input  ssu_pkg::req_t req,
	output ssu_pkg::res_t res
);

	logic [3:0]  nbytes;
	logic [16:0] idx_p1;
	logic [20:0] need;
	logic        bad;
	logic [63:0] le_val;
	logic [63:0] rev;
	logic [63:0] be_val;
	logic [5:0]  be_shift;
	logic [63:0] shifted;
	logic [63:0] mask;
	logic [5:0]  sign_pos;
	logic        full_width;
	logic [63:0] value;

	assign nbytes = cfg.storage_bytes[3:0];
	assign idx_p1 = {1'b0, req.element_index} + 17'd1;
	assign need   = 21'(nbytes * idx_p1);

	assign bad = (cfg.storage_bytes == 5'd0)
		|| (cfg.storage_bytes > 5'(ssu_pkg::MaxStorage))
		|| (cfg.sig_bits == 7'd0)
		|| (cfg.sig_bits > 7'(ssu_pkg::WordBits))
		|| (req.element_index >= cfg.repeat_count)
		|| ({1'b0, req.buffer_bytes} < need);

	// keep the low nbytes bytes; reversed copy for big endian order
	always_comb begin
		for (int i = 0; i < ssu_pkg::MaxStorage; i++) begin
			le_val[i*8 +: 8] = (4'(i) < nbytes) ? req.raw_bytes[i*8 +: 8] : 8'd0;
			rev[i*8 +: 8]    = req.raw_bytes[(ssu_pkg::MaxStorage-1-i)*8 +: 8];
		end
	end

	assign be_shift = {3'(4'd8 - nbytes), 3'b000};
	assign be_val   = rev >> be_shift;
	assign shifted  = (cfg.msb_first ? be_val : le_val) >> cfg.shift_amount;

	assign full_width = (cfg.sig_bits == 7'(ssu_pkg::WordBits));
	assign mask       = full_width ? {64{1'b1}} : ((64'd1 << cfg.sig_bits[5:0]) - 64'd1);
	assign sign_pos   = cfg.sig_bits[5:0] - 6'd1;

	always_comb begin
		value = shifted & mask;
		if (cfg.signed_mode && !full_width && value[sign_pos]) begin
			value = value | ~mask;
		end
	end

	assign res.sample_bits   = bad ? 64'd0 : value;
	assign res.sample_signed = bad ? 1'b0 : cfg.signed_mode;
	assign res.decode_error  = bad;

endmodule

FILE: hdl/sensor_sample_unpacker_core.sv
// ----------------------------------------------------------------------------
// sensor_sample_unpacker_core
// Decodes one sensor sample element per word from raw scan bytes.
// ----------------------------------------------------------------------------
//  channel   valid / stall          payload
//  src       src_valid/src_stall    raw_bytes, element_index, buffer_bytes
//  res       res_valid/res_stall    sample_bits, sample_signed, decode_error
//  cfg       cfg_we                 cfg_idx, cfg_data
//
// one word per cycle sustained while res_stall is low; an accepted word passes
// through the input register, then is decoded into the result register
// arst_n clears valid flags and loads register defaults
// a stalled result holds; the input register keeps taking words until both
// stages are full and res_stall is high
// ----------------------------------------------------------------------------
module sensor_sample_unpacker_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ssu_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [ssu_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         src_valid,
	output logic                         src_stall,
	input  logic [63:0]                  raw_bytes,
	input  logic [15:0]                  element_index,
	input  logic [19:0]                  buffer_bytes,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [63:0]                  sample_bits,
	output logic                         sample_signed,
	output logic                         decode_error
);

	ssu_pkg::cfg_t cfg;
	ssu_pkg::req_t req_s1;
	ssu_pkg::res_t res_comb;
	ssu_pkg::res_t res_s2;
	logic          valid_s1;
	logic          valid_s2;
	logic          adv_s2;
	logic          load_s1;

	ssu_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	ssu_decode u_dec (
		.cfg (cfg),
		.req (req_s1),
		.res (res_comb)
	);

	assign adv_s2    = !valid_s2 || !res_stall;
	assign src_stall = valid_s1 && !adv_s2;
	assign load_s1   = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!src_stall) begin
				valid_s1 <= src_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1.raw_bytes     <= raw_bytes;
			req_s1.element_index <= element_index;
			req_s1.buffer_bytes  <= buffer_bytes;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid     = valid_s2;
	assign sample_bits   = res_s2.sample_bits;
	assign sample_signed = res_s2.sample_signed;
	assign decode_error  = res_s2.decode_error;

	// an accepted word is held in the input register next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted word missing from input register");

	// a word blocked behind a stalled result is not dropped
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && res_stall |=> valid_s1 && valid_s2)
		else $error("word dropped under stall");

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && decode_error |-> sample_bits == 64'd0 && !sample_signed)
		else $error("error result with nonzero value");

	// unsigned results fit in the significant bits
	a_unsigned_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !decode_error && !sample_signed && cfg.sig_bits < 7'd64
		|-> (sample_bits >> cfg.sig_bits[5:0]) == 64'd0)
		else $error("unsigned result wider than significant bits");

endmodule

FILE: bench/sensor_sample_unpacker_core_test.sv
// ----------------------------------------------------------------------------
// sensor_sample_unpacker_core_test
// Self-checking bench for the sensor sample unpacker. A behavioral decoder
// predicts every result from the shadowed register settings. Each word that
// leaves the block is compared field by field with the oldest prediction.
// Stimulus runs in this order: reset defaults, field extremes, bad settings,
// shift and sign cases, then random settings with random idling on both
// sides, and finally a steady stream with no idling.
// ----------------------------------------------------------------------------
module sensor_sample_unpacker_core_test;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [ssu_pkg::CfgIdxW-1:0]  cfg_idx;
	logic [ssu_pkg::CfgDataW-1:0] cfg_data;
	logic                         src_valid;
	logic                         src_stall;
	logic [63:0]                  raw_bytes;
	logic [15:0]                  element_index;
	logic [19:0]                  buffer_bytes;
	logic                         res_valid;
	logic                         res_stall;
	logic [63:0]                  sample_bits;
	logic                         sample_signed;
	logic                         decode_error;

	// register settings as the block should hold them
	ssu_pkg::cfg_t active_cfg = '{1'b0, 1'b0, 7'd16, 5'd2, 16'd1, 6'd0};
	ssu_pkg::res_t pending_samples[$];
	int unsigned mismatch_count = 0;
	bit src_idle_on = 1'b1;
	bit res_idle_on = 1'b1;

	sensor_sample_unpacker_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.raw_bytes     (raw_bytes),
		.element_index (element_index),
		.buffer_bytes  (buffer_bytes),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.sample_bits   (sample_bits),
		.sample_signed (sample_signed),
		.decode_error  (decode_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic ssu_pkg::res_t decode_sample(ssu_pkg::req_t w, ssu_pkg::cfg_t c);
		ssu_pkg::res_t r;
		logic [63:0] word;
		logic [63:0] keep;
		int unsigned n;
		int unsigned need;
		n = c.storage_bytes;
		need = n * (32'(w.element_index) + 32'd1);
		r = '0;
		if (n == 0 || n > ssu_pkg::MaxStorage || c.sig_bits == 0
			|| c.sig_bits > ssu_pkg::WordBits
			|| w.element_index >= c.repeat_count || w.buffer_bytes < need) begin
			r.decode_error = 1'b1;
			return r;
		end
		word = '0;
		// first byte taken ends up most significant
		for (int i = 0; i < n; i++) begin
			word = {word[55:0],
				w.raw_bytes[(c.msb_first ? i : n - 1 - i) * ssu_pkg::ByteBits +: 8]};
		end
		word = word >> c.shift_amount;
		keep = (c.sig_bits == ssu_pkg::WordBits) ? '1 : ((64'd1 << c.sig_bits) - 64'd1);
		word &= keep;
		if (c.signed_mode && c.sig_bits < ssu_pkg::WordBits && word[c.sig_bits - 1])
			word |= ~keep;
		r.sample_bits = word;
		r.sample_signed = c.signed_mode;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch: %s", what);
	endtask

	always @(posedge clk) begin : check_results
		ssu_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("word with nothing pending, sample_bits %h",
					sample_bits));
			end else begin
				want = pending_samples.pop_front();
				if (sample_bits !== want.sample_bits)
					report_mismatch($sformatf("sample_bits %h, want %h", sample_bits,
						want.sample_bits));
				if (sample_signed !== want.sample_signed)
					report_mismatch($sformatf("sample_signed %b, want %b", sample_signed,
						want.sample_signed));
				if (decode_error !== want.decode_error)
					report_mismatch($sformatf("decode_error %b, want %b", decode_error,
						want.decode_error));
			end
		end
	end

	// receiver stalls in bursts, with quiet runs between
	initial begin
		res_stall <= 1'b0;
		forever begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (res_idle_on && $urandom_range(0, 2) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(input ssu_pkg::req_t w);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		src_valid     <= 1'b1;
		raw_bytes     <= w.raw_bytes;
		element_index <= w.element_index;
		buffer_bytes  <= w.buffer_bytes;
		do @(posedge clk); while (src_stall);
		pending_samples.push_back(decode_sample(w, active_cfg));
	endtask

	task automatic hold_until_drained();
		src_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input ssu_pkg::reg_idx_t r,
		input logic [ssu_pkg::CfgDataW-1:0] d);
		cfg_we   <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			ssu_pkg::REG_MSB_FIRST:     active_cfg.msb_first     = d[0];
			ssu_pkg::REG_SIGNED_MODE:   active_cfg.signed_mode   = d[0];
			ssu_pkg::REG_SIG_BITS:      active_cfg.sig_bits      = d[6:0];
			ssu_pkg::REG_STORAGE_BYTES: active_cfg.storage_bytes = d[4:0];
			ssu_pkg::REG_REPEAT_COUNT:  active_cfg.repeat_count  = d[15:0];
			ssu_pkg::REG_SHIFT_AMOUNT:  active_cfg.shift_amount  = d[5:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// unused upper data bits carry junk, the block must drop them
	task automatic set_cfg(input ssu_pkg::cfg_t c);
		logic [15:0] junk;
		hold_until_drained();
		junk = 16'($urandom);
		write_reg(ssu_pkg::REG_MSB_FIRST, {junk[15:1], c.msb_first});
		write_reg(ssu_pkg::REG_SIGNED_MODE, {junk[15:1], c.signed_mode});
		write_reg(ssu_pkg::REG_SIG_BITS, {junk[15:7], c.sig_bits});
		write_reg(ssu_pkg::REG_STORAGE_BYTES, {junk[15:5], c.storage_bytes});
		write_reg(ssu_pkg::REG_REPEAT_COUNT, c.repeat_count);
		write_reg(ssu_pkg::REG_SHIFT_AMOUNT, {junk[15:6], c.shift_amount});
	endtask

	function automatic ssu_pkg::cfg_t random_cfg();
		ssu_pkg::cfg_t c;
		int unsigned roll;
		c.msb_first = 1'($urandom_range(0, 1));
		c.signed_mode = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 29);
		if (roll == 0)
			c.sig_bits = 7'($urandom_range(65, 127));
		else if (roll == 1)
			c.sig_bits = 7'd0;
		else if (roll < 6)
			c.sig_bits = 7'd64;
		else
			c.sig_bits = 7'($urandom_range(1, 64));
		roll = $urandom_range(0, 29);
		if (roll == 0)
			c.storage_bytes = 5'd0;
		else if (roll == 1)
			c.storage_bytes = 5'($urandom_range(9, 31));
		else if (roll < 6)
			c.storage_bytes = 5'd8;
		else
			c.storage_bytes = 5'($urandom_range(1, 8));
		roll = $urandom_range(0, 29);
		if (roll == 0)
			c.repeat_count = 16'd0;
		else if (roll < 4)
			c.repeat_count = 16'hFFFF;
		else if (roll < 9)
			c.repeat_count = 16'($urandom);
		else
			c.repeat_count = 16'($urandom_range(1, 8));
		roll = $urandom_range(0, 9);
		if (roll == 0)
			c.shift_amount = 6'd63;
		else if (roll < 4)
			c.shift_amount = 6'($urandom_range(0, 63));
		else if (roll < 6)
			c.shift_amount = 6'd0;
		else
			c.shift_amount = 6'($urandom_range(0, 7));
		return c;
	endfunction

	// mostly in-range index and fitting buffer, some short buffers and noise
	function automatic ssu_pkg::req_t make_request(ssu_pkg::cfg_t c);
		ssu_pkg::req_t w;
		int unsigned need;
		int unsigned top;
		w.raw_bytes = {$urandom, $urandom};
		if ($urandom_range(0, 19) == 0)
			w.raw_bytes = ($urandom_range(0, 1) == 0) ? '0 : '1;
		if ($urandom_range(0, 9) < 8 && c.repeat_count != 0) begin
			top = (c.repeat_count > 4 && $urandom_range(0, 1) == 0) ? 3 : c.repeat_count - 1;
			w.element_index = 16'($urandom_range(0, top));
			need = c.storage_bytes * (32'(w.element_index) + 32'd1);
			case ($urandom_range(0, 5))
				0: need = need;
				1: need = (need == 0) ? 0 : need - 1;
				2: need = 32'hFFFFF;
				default: need = need + $urandom_range(0, 40);
			endcase
			w.buffer_bytes = (need > 32'hFFFFF) ? 20'hFFFFF : 20'(need);
		end else begin
			w.element_index = 16'($urandom);
			w.buffer_bytes = 20'($urandom);
		end
		return w;
	endfunction

	task automatic test_reset_defaults();
		send_word('{64'hFEDC_BA98_7654_3210, 16'd0, 20'd2});
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 20'd4});
		send_word('{64'h0123_4567_89AB_CDEF, 16'd0, 20'd1});
	endtask

	task automatic test_field_extremes();
		ssu_pkg::cfg_t c;
		c = '{1'b1, 1'b1, 7'd64, 5'd8, 16'hFFFF, 6'd0};
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd65534, 20'hFFFFF});
		send_word('{64'h0123_4567_89AB_CDEF, 16'd0, 20'd8});
		send_word('{64'h8000_0000_0000_0001, 16'd65535, 20'hFFFFF});
		send_word('{64'h0123_4567_89AB_CDEF, 16'd3, 20'd31});
	endtask

	task automatic test_bad_settings();
		ssu_pkg::cfg_t c;
		c = '{1'b0, 1'b1, 7'd16, 5'd0, 16'd4, 6'd0};
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'hFFFFF});
		c.storage_bytes = 5'd9;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'hFFFFF});
		c.storage_bytes = 5'd31;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'hFFFFF});
		c.storage_bytes = 5'd4;
		c.sig_bits = 7'd0;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'hFFFFF});
		c.sig_bits = 7'd65;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'hFFFFF});
		c.sig_bits = 7'd127;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'hFFFFF});
		c.sig_bits = 7'd32;
		c.repeat_count = 16'd0;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'hFFFFF});
	endtask

	task automatic test_shift_and_sign();
		ssu_pkg::cfg_t c;
		c = '{1'b0, 1'b0, 7'd64, 5'd8, 16'd4, 6'd63};
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'd8});
		// shift past the stored bits leaves nothing
		c.storage_bytes = 5'd2;
		c.shift_amount = 6'd16;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 20'd2});
		// 12 significant bits from 3 stored bytes, upper raw bytes must be ignored
		c = '{1'b0, 1'b1, 7'd12, 5'd3, 16'd2, 6'd4};
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FF8A_F321, 16'd1, 20'd6});
		send_word('{64'hFFFF_FFFF_FF8A_7321, 16'd0, 20'd3});
		c.msb_first = 1'b1;
		set_cfg(c);
		send_word('{64'hFFFF_FFFF_FF8A_F321, 16'd1, 20'd6});
	endtask

	task automatic test_random_settings();
		ssu_pkg::cfg_t c;
		int unsigned n;
		for (int phase = 0; phase < 22; phase++) begin
			if (phase == 0)
				c = '{1'b0, 1'b0, 7'd1, 5'd1, 16'd1, 6'd0};
			else if (phase == 1)
				c = '{1'b1, 1'b1, 7'd64, 5'd8, 16'hFFFF, 6'd63};
			else
				c = random_cfg();
			set_cfg(c);
			n = $urandom_range(40, 70);
			repeat (n) send_word(make_request(c));
		end
	endtask

	task automatic test_steady_stream();
		ssu_pkg::cfg_t c;
		src_idle_on = 1'b0;
		res_idle_on = 1'b0;
		repeat (2) begin
			c = random_cfg();
			set_cfg(c);
			repeat (160) send_word(make_request(c));
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_idx       <= ssu_pkg::REG_MSB_FIRST;
		cfg_data      <= '0;
		src_valid     <= 1'b0;
		raw_bytes     <= '0;
		element_index <= '0;
		buffer_bytes  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_bad_settings();
		test_shift_and_sign();
		test_random_settings();
		test_steady_stream();

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (pending_samples.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", pending_samples.size()));
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
